[src/agc_pkg.sv]
// agc_pkg: shared constants and types for the audio gain / rectify chain.
// Used by agc_step and audio_gain_abs_chain; depends on nothing.
package agc_pkg;

  // chain length: bounded by the step limit and by the gain registers
  localparam int MAX_STEPS = 4;
  localparam int GAIN_REGS = 4;
  localparam int NUM_STEPS = (MAX_STEPS < GAIN_REGS) ? MAX_STEPS : GAIN_REGS;

  // field and register widths
  localparam int SAMPLE_W   = 8;
  localparam int CNT_W      = 3;
  localparam int KINDS_W    = 4;
  localparam int GAIN_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // gain datapath widths
  localparam int FACTOR_W = 12;   // 100 + percent
  localparam int CENT_W   = 9;    // sample - midpoint
  localparam int PROD_W   = CENT_W + FACTOR_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int MID100_W = 15;   // midpoint * 100
  localparam int T_W      = 15;   // rounded sum below the clip level

  // round half up, divide by 100, clip level for results above 255
  localparam int ROUND_BIAS  = 50;
  localparam int SAT_LIMIT   = 25600;
  localparam int PCT_BASE    = 100;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 16'd41944;  // ceil(2^22 / 100)
  localparam int Q_W         = T_W + RECIP_W;

  localparam logic [SAMPLE_W-1:0] MID_RESET = 8'd128;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT = 3'd0,
    REG_STEP_KINDS = 3'd1,
    REG_GAIN0      = 3'd2,
    REG_GAIN1      = 3'd3,
    REG_GAIN2      = 3'd4,
    REG_GAIN3      = 3'd5,
    REG_MIDPOINT   = 3'd6
  } cfg_reg_t;

  // per-step control derived from the configuration registers
  typedef struct packed {
    logic                       active;
    logic                       is_gain;
    logic signed [FACTOR_W-1:0] factor;
    logic [SAMPLE_W-1:0]        mid;
    logic [MID100_W-1:0]        mid100;
  } step_cfg_t;

endpackage

[src/audio_gain_abs_chain.sv]
// audio_gain_abs_chain: top level, configuration registers and the step chain.
// Depends on agc_pkg and agc_step.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tdata[7:0]  = sample_in
//  out_    | master    | out_tvalid / out_tready| out_tdata[7:0] = sample_out
//  cfg_    | write     | cfg_wen                | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ is not stalled; each chain step
// registers its data through its multiply, round/compare and reciprocal-divide
// stages in turn. Inactive steps still pass data through their stages.
// Synchronous active-low reset clears all valid bits and config, midpoint to 128.
// A stall on out_ holds the last stage; earlier stages keep filling bubbles.
module audio_gain_abs_chain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] sample_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] sample_out
  input  logic                           cfg_wen,
  input  logic [agc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NS = agc_pkg::NUM_STEPS;

  // configuration registers
  logic [agc_pkg::CNT_W-1:0]          step_count_r;
  logic [agc_pkg::KINDS_W-1:0]        step_kinds_r;
  logic signed [agc_pkg::GAIN_W-1:0]  gain_r [agc_pkg::GAIN_REGS];
  logic [agc_pkg::SAMPLE_W-1:0]       mid_r;

  logic [agc_pkg::CNT_W-1:0]          cnt_eff;
  logic [agc_pkg::MID100_W-1:0]       mid100;
  agc_pkg::step_cfg_t                 step_cfg [NS];

  // chain links
  logic                               link_valid [NS+1];
  logic                               link_ready [NS+1];
  logic [agc_pkg::SAMPLE_W-1:0]       link_sample [NS+1];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      step_kinds_r <= '0;
      gain_r[0]    <= '0;
      gain_r[1]    <= '0;
      gain_r[2]    <= '0;
      gain_r[3]    <= '0;
      mid_r        <= agc_pkg::MID_RESET;
    end else if (cfg_wen) begin
      case (agc_pkg::cfg_reg_t'(cfg_index))
        agc_pkg::REG_STEP_COUNT: step_count_r <= cfg_wdata[agc_pkg::CNT_W-1:0];
        agc_pkg::REG_STEP_KINDS: step_kinds_r <= cfg_wdata[agc_pkg::KINDS_W-1:0];
        agc_pkg::REG_GAIN0:      gain_r[0]    <= $signed(cfg_wdata[agc_pkg::GAIN_W-1:0]);
        agc_pkg::REG_GAIN1:      gain_r[1]    <= $signed(cfg_wdata[agc_pkg::GAIN_W-1:0]);
        agc_pkg::REG_GAIN2:      gain_r[2]    <= $signed(cfg_wdata[agc_pkg::GAIN_W-1:0]);
        agc_pkg::REG_GAIN3:      gain_r[3]    <= $signed(cfg_wdata[agc_pkg::GAIN_W-1:0]);
        agc_pkg::REG_MIDPOINT:   mid_r        <= cfg_wdata[agc_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // active step count saturates at the chain length
  assign cnt_eff = (step_count_r > agc_pkg::CNT_W'(NS)) ? agc_pkg::CNT_W'(NS) : step_count_r;
  assign mid100  = agc_pkg::MID100_W'(mid_r) * agc_pkg::MID100_W'(agc_pkg::PCT_BASE);

  assign link_valid[0]  = in_tvalid;
  assign in_tready      = link_ready[0];
  assign link_sample[0] = in_tdata;

  // step chain
  for (genvar i = 0; i < NS; i++) begin : g_step
    always_comb begin
      step_cfg[i].active  = (agc_pkg::CNT_W'(i) < cnt_eff);
      step_cfg[i].is_gain = step_kinds_r[i];
      step_cfg[i].factor  = $signed({gain_r[i][agc_pkg::GAIN_W-1], gain_r[i]})
                          + $signed(agc_pkg::FACTOR_W'(agc_pkg::PCT_BASE));
      step_cfg[i].mid     = mid_r;
      step_cfg[i].mid100  = mid100;
    end

    agc_step u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .cfg        (step_cfg[i]),
      .in_valid   (link_valid[i]),
      .in_ready   (link_ready[i]),
      .in_sample  (link_sample[i]),
      .out_valid  (link_valid[i+1]),
      .out_ready  (link_ready[i+1]),
      .out_sample (link_sample[i+1])
    );
  end

  assign out_tvalid     = link_valid[NS];
  assign link_ready[NS] = out_tready;
  assign out_tdata      = link_sample[NS];

`ifndef ASSERT_OFF
  // a ready sink lets the whole chain advance
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // an empty output stage means the chain cannot be backed up
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");
`endif

endmodule

[src/agc_step.sv]
// agc_step: one chain step as a three-stage pipeline (multiply, round/compare,
// reciprocal divide and clip). Depends on agc_pkg.
module agc_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  agc_pkg::step_cfg_t            cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [agc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [agc_pkg::SAMPLE_W-1:0]  out_sample
);

  // stage valid bits and per-stage ready
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // stage 1 payload
  logic signed [agc_pkg::PROD_W-1:0]   prod_r;
  logic [agc_pkg::SAMPLE_W-1:0]        alt1_r;
  logic                                gain1_r;
  // stage 2 payload
  logic [agc_pkg::T_W-1:0]             t_r;
  logic                                neg_r, sat_r, gain2_r;
  logic [agc_pkg::SAMPLE_W-1:0]        alt2_r;
  // stage 3 payload
  logic [agc_pkg::SAMPLE_W-1:0]        sample_r;

  // stage 1 logic
  logic signed [agc_pkg::CENT_W-1:0]   cent;
  logic signed [agc_pkg::PROD_W-1:0]   prod_nxt;
  logic [agc_pkg::SAMPLE_W-1:0]        abs_mag;
  logic [agc_pkg::SAMPLE_W:0]          abs_sum;
  logic [agc_pkg::SAMPLE_W-1:0]        alt_nxt;

  // stage 2 logic
  logic signed [agc_pkg::SUM_W-1:0]    t_sum;

  // stage 3 logic
  logic [agc_pkg::Q_W-1:0]             q_full;
  logic [agc_pkg::SAMPLE_W-1:0]        q_val;
  logic [agc_pkg::SAMPLE_W-1:0]        sample_nxt;

  // ready ripples back: a stage takes data when empty or draining
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // excursion, its product with the gain factor, and the mirror result
  always_comb begin
    cent     = $signed({1'b0, in_sample}) - $signed({1'b0, cfg.mid});
    prod_nxt = cent * cfg.factor;
    abs_mag  = cent[agc_pkg::CENT_W-1] ? agc_pkg::SAMPLE_W'(-cent)
                                       : agc_pkg::SAMPLE_W'(cent);
    abs_sum  = {1'b0, abs_mag} + {1'b0, cfg.mid};
    if (!cfg.active) begin
      alt_nxt = in_sample;
    end else if (abs_sum[agc_pkg::SAMPLE_W]) begin
      alt_nxt = '1;
    end else begin
      alt_nxt = abs_sum[agc_pkg::SAMPLE_W-1:0];
    end
  end

  // add back midpoint*100 and the rounding bias, flag the clip cases
  assign t_sum = $signed({{(agc_pkg::SUM_W - agc_pkg::MID100_W){1'b0}}, cfg.mid100})
               + $signed({prod_r[agc_pkg::PROD_W-1], prod_r})
               + $signed(agc_pkg::SUM_W'(agc_pkg::ROUND_BIAS));

  // divide by 100 through the reciprocal, then pick the step result
  always_comb begin
    q_full = agc_pkg::Q_W'(t_r) * agc_pkg::Q_W'(agc_pkg::RECIP);
    q_val  = q_full[agc_pkg::RECIP_SHIFT + agc_pkg::SAMPLE_W - 1 : agc_pkg::RECIP_SHIFT];
    if (!gain2_r) begin
      sample_nxt = alt2_r;
    end else if (neg_r) begin
      sample_nxt = '0;
    end else if (sat_r) begin
      sample_nxt = '1;
    end else begin
      sample_nxt = q_val;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      prod_r  <= prod_nxt;
      alt1_r  <= alt_nxt;
      gain1_r <= cfg.active && cfg.is_gain;
    end
    if (rdy2 && v1_r) begin
      t_r     <= t_sum[agc_pkg::T_W-1:0];
      neg_r   <= t_sum[agc_pkg::SUM_W-1];
      sat_r   <= (t_sum[agc_pkg::SUM_W-2:0] >= (agc_pkg::SUM_W-1)'(agc_pkg::SAT_LIMIT));
      gain2_r <= gain1_r;
      alt2_r  <= alt1_r;
    end
    if (rdy3 && v2_r) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid  = v3_r;
  assign out_sample = sample_r;

endmodule
